// ===== sv/mglt_pkg.sv =====
// ----------------------------------------------------------------------------
// mglt_pkg
// Types and constants shared by the multigranularity lock table modules.
// ----------------------------------------------------------------------------
package mglt_pkg;

  localparam logic [2:0] MODE_S   = 3'd0;
  localparam logic [2:0] MODE_X   = 3'd1;
  localparam logic [2:0] MODE_IS  = 3'd2;
  localparam logic [2:0] MODE_IX  = 3'd3;
  localparam logic [2:0] MODE_SIX = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHRINK   = 3'd1;
  localparam logic [2:0] ST_UPGRADE  = 3'd2;
  localparam logic [2:0] ST_CONFLICT = 3'd3;
  localparam logic [2:0] ST_NOT_HELD = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  localparam logic [1:0] PH_DEFAULT   = 2'd0;
  localparam logic [1:0] PH_GROWING   = 2'd1;
  localparam logic [1:0] PH_SHRINKING = 2'd2;

  localparam logic OP_LOCK   = 1'b0;
  localparam logic OP_UNLOCK = 1'b1;

  localparam int unsigned KEY_W = 59;

  typedef struct packed {
    logic        op;
    logic [15:0] txn_id;
    logic [1:0]  txn_phase;
    logic        is_record;
    logic [9:0]  table_id;
    logic [31:0] record_page;
    logic [15:0] record_slot;
    logic [2:0]  mode;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] new_phase;
    logic [2:0] held_mode;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // capture request and clear scan flags
    logic scan;     // examine one entry at the scan index
    logic commit;   // apply the decision and build the result
  } mglt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last;
  } mglt_sts_t;

  function automatic logic [2:0] combine(input logic [2:0] held, input logic [2:0] req);
    logic [2:0] r;
    begin
      r = MODE_X;
      unique case (held)
        MODE_S: begin
          unique case (req)
            MODE_S, MODE_IS: r = MODE_S;
            MODE_IX, MODE_SIX: r = MODE_SIX;
            default: r = MODE_X;
          endcase
        end
        MODE_IS: begin
          r = req;
        end
        MODE_IX: begin
          unique case (req)
            MODE_IS, MODE_IX: r = MODE_IX;
            MODE_S, MODE_SIX: r = MODE_SIX;
            default: r = MODE_X;
          endcase
        end
        MODE_SIX: begin
          r = (req == MODE_X) ? MODE_X : MODE_SIX;
        end
        default: r = MODE_X;
      endcase
      return r;
    end
  endfunction

  function automatic logic [4:0] compat_row(input logic [2:0] m);
    logic [4:0] r;
    begin
      unique case (m)
        MODE_S:   r = 5'h05;
        MODE_IS:  r = 5'h1D;
        MODE_IX:  r = 5'h0C;
        MODE_SIX: r = 5'h04;
        default:  r = 5'h00;
      endcase
      return r;
    end
  endfunction

  function automatic logic compatible(input logic [2:0] a, input logic [2:0] b);
    logic [4:0] ra;
    logic [4:0] rb;
    begin
      ra = compat_row(a);
      rb = compat_row(b);
      if (a > MODE_SIX || b > MODE_SIX) return 1'b0;
      return ra[b] & rb[a];
    end
  endfunction

endpackage

// ===== sv/mglt_datapath.sv =====
// ----------------------------------------------------------------------------
// mglt_datapath
// Lock entry store, request register, serial entry scan and result logic.
// ----------------------------------------------------------------------------
module mglt_datapath import mglt_pkg::*; #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  mglt_cmd_t cmd,
  output mglt_sts_t sts,
  input  in_item_t  in_item,
  output out_item_t result
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [ENTRIES-1:0] valid_r;
  logic [KEY_W-1:0]   res_mem [ENTRIES];
  logic [15:0]        own_mem [ENTRIES];
  logic [2:0]         mode_mem[ENTRIES];

  logic [KEY_W-1:0] rd_key_r;
  logic [15:0]      rd_own_r;
  logic [2:0]       rd_mode_r;
  logic             rd_vld_r;
  logic [IW-1:0]    rd_idx_r;
  logic             rd_live_r;

  logic             op_r;
  logic [15:0]      txn_r;
  logic [1:0]       phase_r;
  logic [KEY_W-1:0] key_r;
  logic [2:0]       req_r;

  logic [IW-1:0] idx_r;
  logic          own_hit_r;
  logic [IW-1:0] own_idx_r;
  logic [2:0]    own_mode_r;
  logic          free_hit_r;
  logic [IW-1:0] free_idx_r;
  logic [4:0]    other_ok_r;     // per candidate mode, compatible with other holders
  logic          all_ok_r;       // requested mode compatible with all holders

  logic [2:0]    cur_mode;
  logic [2:0]    up_mode;
  logic          same_key;
  logic [4:0]    row_ok;
  out_item_t     res_nxt;

  assign sts.scan_last = (idx_r == IW'(ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_key_r  <= res_mem[idx_r];
      rd_own_r  <= own_mem[idx_r];
      rd_mode_r <= mode_mem[idx_r];
      rd_vld_r  <= valid_r[idx_r];
      rd_idx_r  <= idx_r;
    end
  end

  assign same_key = rd_vld_r && (rd_key_r == key_r);

  always_comb begin
    for (int m = 0; m < 5; m++) begin
      row_ok[m] = compatible(rd_mode_r, 3'(m));
    end
  end

  assign cur_mode = (own_mode_r > MODE_SIX) ? MODE_X : own_mode_r;
  assign up_mode  = combine(cur_mode, req_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_live_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      rd_live_r <= cmd.scan;
      if (cmd.load || cmd.commit) begin
        idx_r <= '0;
      end else if (cmd.scan) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_item.op;
      txn_r      <= in_item.txn_id;
      phase_r    <= (in_item.txn_phase == 2'd3) ? PH_DEFAULT : in_item.txn_phase;
      req_r      <= (in_item.mode > MODE_SIX) ? MODE_X : in_item.mode;
      key_r      <= in_item.is_record ?
                    {1'b1, in_item.table_id, in_item.record_page, in_item.record_slot} :
                    {1'b0, in_item.table_id, 48'd0};
      own_hit_r  <= 1'b0;
      free_hit_r <= 1'b0;
      other_ok_r <= '1;
      all_ok_r   <= 1'b1;
    end else if (rd_live_r) begin
      if (same_key && rd_own_r == txn_r) begin
        if (!own_hit_r) begin
          own_hit_r  <= 1'b1;
          own_idx_r  <= rd_idx_r;
          own_mode_r <= rd_mode_r;
        end
      end else if (same_key) begin
        other_ok_r <= other_ok_r & row_ok;
      end
      if (same_key && !row_ok[req_r]) all_ok_r <= 1'b0;
      if (!rd_vld_r && !free_hit_r) begin
        free_hit_r <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
    end
  end

  always_comb begin
    res_nxt.status    = ST_OK;
    res_nxt.new_phase = phase_r;
    res_nxt.held_mode = MODE_S;
    if (op_r == OP_UNLOCK) begin
      if (!own_hit_r) res_nxt.status = ST_NOT_HELD;
      else if (phase_r == PH_GROWING) res_nxt.new_phase = PH_SHRINKING;
    end else if (phase_r == PH_SHRINKING) begin
      res_nxt.status = ST_SHRINK;
    end else if (own_hit_r) begin
      if (up_mode == cur_mode) begin
        res_nxt.held_mode = cur_mode;
      end else if (!other_ok_r[up_mode]) begin
        res_nxt.status = ST_UPGRADE;
      end else begin
        res_nxt.held_mode = up_mode;
      end
    end else if (!all_ok_r) begin
      res_nxt.status = ST_CONFLICT;
    end else if (!free_hit_r) begin
      res_nxt.status = ST_FULL;
    end else begin
      res_nxt.held_mode = req_r;
      res_nxt.new_phase = PH_GROWING;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) result <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit) begin
      if (op_r == OP_UNLOCK) begin
        if (own_hit_r) valid_r[own_idx_r] <= 1'b0;
      end else if (phase_r != PH_SHRINKING && !own_hit_r && all_ok_r && free_hit_r) begin
        valid_r[free_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && op_r == OP_LOCK && phase_r != PH_SHRINKING) begin
      if (own_hit_r) begin
        if (up_mode != cur_mode && other_ok_r[up_mode]) mode_mem[own_idx_r] <= up_mode;
      end else if (all_ok_r && free_hit_r) begin
        res_mem[free_idx_r]  <= key_r;
        own_mem[free_idx_r]  <= txn_r;
        mode_mem[free_idx_r] <= req_r;
      end
    end
  end

endmodule

// ===== sv/mglt_ctrl.sv =====
// ----------------------------------------------------------------------------
// mglt_ctrl
// Sequencer for one transaction: capture, entry scan, commit and hand-off.
// ----------------------------------------------------------------------------
module mglt_ctrl import mglt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output mglt_cmd_t cmd,
  input  mglt_sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_COMMIT = 5'b01000,
    S_SPARE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/multigranularity_lock_table_top.sv =====
// ----------------------------------------------------------------------------
// multigranularity_lock_table_top
// No-wait two-phase lock table with S, X, IS, IX and SIX modes.
// ----------------------------------------------------------------------------
// Flow: a transaction is taken only in idle, its entries are scanned serially,
// one entry a cycle, and the registered result is then committed. A new
// transaction is not taken until the last one has committed and its result is taken.
// Reset: synchronous, active low; clears every entry valid bit and the
// sequencer. No clearing pass is needed.
module multigranularity_lock_table_top import mglt_pkg::*; #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  mglt_cmd_t cmd;
  mglt_sts_t sts;

  mglt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mglt_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_item (in_data),
    .result  (out_data)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock table testbench
// Drives lock and unlock transactions into the lock table, predicts each
// status, phase and held mode from a model of the entry store, and compares
// every result in order. Random stimulus is mostly lock/unlock traffic on a
// small pool of transactions and resources, with noise on every field.
// ----------------------------------------------------------------------------
module tb;
  import mglt_pkg::*;

  localparam int DEPTH = 64;
  localparam int IN_W  = $bits(in_item_t);

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      in_taken;

  multigranularity_lock_table_top #(.ENTRIES(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  logic        lk_valid [DEPTH];
  logic [58:0] lk_res [DEPTH];
  logic [15:0] lk_owner [DEPTH];
  logic [2:0]  lk_mode [DEPTH];

  in_item_t  pending_q[$];
  out_item_t expected_q[$];
  int        errors;
  int        send_idle;
  int        recv_stall;

  logic [15:0] txn_pool [4];
  logic [9:0]  tab_pool [3];
  logic [31:0] page_pool [2];
  logic [15:0] slot_pool [2];

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [2:0] merge_mode(input logic [2:0] h, input logic [2:0] r);
    logic [2:0] m;
    m = MODE_X;
    case (h)
      MODE_S:   m = (r == MODE_S || r == MODE_IS) ? MODE_S :
                    (r == MODE_IX || r == MODE_SIX) ? MODE_SIX : MODE_X;
      MODE_IS:  m = r;
      MODE_IX:  m = (r == MODE_IS || r == MODE_IX) ? MODE_IX :
                    (r == MODE_S || r == MODE_SIX) ? MODE_SIX : MODE_X;
      MODE_SIX: m = (r == MODE_X) ? MODE_X : MODE_SIX;
      default:  m = MODE_X;
    endcase
    return m;
  endfunction

  function automatic logic admits(input logic [2:0] h, input logic [2:0] r);
    logic [4:0] row;
    case (h)
      MODE_S:   row = 5'h05;
      MODE_IS:  row = 5'h1D;
      MODE_IX:  row = 5'h0C;
      MODE_SIX: row = 5'h04;
      default:  row = 5'h00;
    endcase
    if (r > MODE_SIX) return 1'b0;
    return row[r];
  endfunction

  function automatic logic modes_agree(input logic [2:0] a, input logic [2:0] b);
    return admits(a, b) && admits(b, a);
  endfunction

  function automatic out_item_t lock_outcome(input in_item_t it);
    out_item_t   r;
    logic [1:0]  ph;
    logic [2:0]  req;
    logic [2:0]  cur;
    logic [2:0]  nm;
    logic [58:0] key;
    int          own;
    int          free_slot;
    ph = (it.txn_phase == 2'd3) ? PH_DEFAULT : it.txn_phase;
    req = (it.mode > MODE_SIX) ? MODE_X : it.mode;
    key = {it.is_record, it.table_id, 48'd0};
    if (it.is_record) key[47:0] = {it.record_page, it.record_slot};
    r = '0;
    r.status = ST_OK;
    own = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (own < 0 && lk_valid[i] && lk_res[i] == key && lk_owner[i] == it.txn_id) own = i;
    end
    if (it.op == OP_UNLOCK) begin
      if (own < 0) begin
        r.status = ST_NOT_HELD;
      end else begin
        lk_valid[own] = 1'b0;
        if (ph == PH_GROWING) ph = PH_SHRINKING;
      end
    end else if (ph == PH_SHRINKING) begin
      r.status = ST_SHRINK;
    end else if (own >= 0) begin
      cur = (lk_mode[own] > MODE_SIX) ? MODE_X : lk_mode[own];
      nm = merge_mode(cur, req);
      if (nm == cur) begin
        r.held_mode = cur;
      end else begin
        for (int i = 0; i < DEPTH; i++) begin
          if (lk_valid[i] && lk_res[i] == key && lk_owner[i] != it.txn_id &&
              !modes_agree(lk_mode[i], nm)) r.status = ST_UPGRADE;
        end
        if (r.status == ST_OK) begin
          lk_mode[own] = nm;
          r.held_mode = nm;
        end
      end
    end else begin
      free_slot = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (lk_valid[i]) begin
          if (lk_res[i] == key && !modes_agree(lk_mode[i], req)) r.status = ST_CONFLICT;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (r.status == ST_OK) begin
        if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          lk_valid[free_slot] = 1'b1;
          lk_res[free_slot] = key;
          lk_owner[free_slot] = it.txn_id;
          lk_mode[free_slot] = req;
          r.held_mode = req;
          ph = PH_GROWING;
        end
      end
    end
    r.new_phase = ph;
    return r;
  endfunction

  function automatic in_item_t traffic_item();
    in_item_t it;
    it = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
    it.op = ($urandom_range(0, 2) == 0) ? OP_UNLOCK : OP_LOCK;
    it.txn_id = txn_pool[$urandom_range(0, 3)];
    it.txn_phase = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(0, 3)) :
                   2'($urandom_range(0, 1));
    it.table_id = tab_pool[$urandom_range(0, 2)];
    it.record_page = page_pool[$urandom_range(0, 1)];
    it.record_slot = slot_pool[$urandom_range(0, 1)];
    it.mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) :
              3'($urandom_range(0, 4));
    return it;
  endfunction

  function automatic in_item_t make_item(input logic op, input logic [15:0] txn,
                                         input logic [1:0] ph, input logic rec,
                                         input logic [9:0] tab, input logic [2:0] m);
    in_item_t it;
    it = '0;
    it.op = op;
    it.txn_id = txn;
    it.txn_phase = ph;
    it.is_record = rec;
    it.table_id = tab;
    it.record_page = 32'hFFFF_FFFF;
    it.record_slot = 16'hFFFF;
    it.mode = m;
    return it;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        in_data <= pending_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall);
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      expected_q.push_back(lock_outcome(in_data));
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %p", out_data);
        errors++;
      end else begin
        if (out_data.status !== expected_q[0].status) begin
          $error("status expected %0d actual %0d", expected_q[0].status, out_data.status);
          errors++;
        end
        if (out_data.new_phase !== expected_q[0].new_phase) begin
          $error("new_phase expected %0d actual %0d", expected_q[0].new_phase,
                 out_data.new_phase);
          errors++;
        end
        if (out_data.held_mode !== expected_q[0].held_mode) begin
          $error("held_mode expected %0d actual %0d", expected_q[0].held_mode,
                 out_data.held_mode);
          errors++;
        end
        void'(expected_q.pop_front());
      end
    end
  end

  task automatic drain();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    #4000000;
    $display("** multigranularity_lock_table_top: FAILED **");
    $finish;
  end

  initial begin
    errors = 0;
    send_idle = 0;
    recv_stall = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_taken = 1'b0;
    out_ready = 1'b0;
    in_data = '0;
    for (int i = 0; i < DEPTH; i++) lk_valid[i] = 1'b0;
    txn_pool = '{16'd0, 16'hFFFF, 16'd7, 16'($urandom)};
    tab_pool = '{10'd0, 10'h3FF, 10'($urandom)};
    page_pool = '{32'd0, 32'hFFFF_FFFF};
    slot_pool = '{16'd0, 16'hFFFF};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    pending_q.push_back(make_item(OP_UNLOCK, 16'd1, PH_DEFAULT, 1'b0, 10'd0, MODE_S));
    pending_q.push_back(make_item(OP_LOCK, 16'd1, PH_DEFAULT, 1'b0, 10'd0, MODE_IS));
    pending_q.push_back(make_item(OP_LOCK, 16'd1, PH_GROWING, 1'b0, 10'd0, MODE_IS));
    pending_q.push_back(make_item(OP_LOCK, 16'd2, 2'd3, 1'b0, 10'd0, MODE_IX));
    pending_q.push_back(make_item(OP_LOCK, 16'd1, PH_GROWING, 1'b0, 10'd0, MODE_S));
    pending_q.push_back(make_item(OP_LOCK, 16'd3, PH_DEFAULT, 1'b0, 10'd0, MODE_S));
    pending_q.push_back(make_item(OP_LOCK, 16'd3, PH_DEFAULT, 1'b0, 10'd0, MODE_X));
    pending_q.push_back(make_item(OP_LOCK, 16'd2, PH_GROWING, 1'b0, 10'd0, MODE_SIX));
    pending_q.push_back(make_item(OP_LOCK, 16'hFFFF, PH_SHRINKING, 1'b1, 10'h3FF, MODE_S));
    pending_q.push_back(make_item(OP_LOCK, 16'hFFFF, PH_DEFAULT, 1'b1, 10'h3FF, 3'd7));
    pending_q.push_back(make_item(OP_LOCK, 16'hFFFF, PH_GROWING, 1'b1, 10'h3FF, 3'd5));
    pending_q.push_back(make_item(OP_UNLOCK, 16'hFFFF, PH_GROWING, 1'b1, 10'h3FF, 3'd6));
    pending_q.push_back(make_item(OP_UNLOCK, 16'd1, PH_SHRINKING, 1'b0, 10'd0, MODE_X));
    pending_q.push_back(make_item(OP_UNLOCK, 16'd2, 2'd3, 1'b0, 10'd0, MODE_X));
    for (int i = 0; i < DEPTH + 1; i++) begin
      pending_q.push_back(make_item(OP_LOCK, 16'(100 + i), PH_GROWING, 1'b0,
                                    10'(i), MODE_SIX));
    end
    pending_q.push_back(make_item(OP_LOCK, 16'd500, PH_DEFAULT, 1'b0, 10'd0, MODE_X));
    drain();
    for (int i = 0; i < DEPTH; i++) begin
      pending_q.push_back(make_item(OP_UNLOCK, 16'(100 + i), PH_GROWING, 1'b0,
                                    10'(i), MODE_S));
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1) ? 51 : (ph == 3) ? 32 : 0;
      recv_stall = (ph == 2) ? 51 : (ph == 3) ? 32 : 0;
      for (int n = 0; n < 110; n++) begin
        pending_q.push_back(($urandom_range(0, 9) == 0) ?
                            in_item_t'(IN_W'({$urandom, $urandom, $urandom})) :
                            traffic_item());
      end
      drain();
    end
    send_idle = 0;
    recv_stall = 0;

    repeat (DEPTH * 2 + 20) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("** multigranularity_lock_table_top: PASSED **");
    end else begin
      $display("** multigranularity_lock_table_top: FAILED **");
    end
    $finish;
  end
endmodule
